// ===== rtl/core/skmx_pkg.sv =====
// Shared types and constants for the super-k-mer canonical k-mer extractor.
// No dependencies; used by every module under rtl/core except skmx_fifo.
`timescale 1ns / 1ps

package skmx_pkg;

  localparam int KMER_WORD_BITS = 64;
  localparam int KLEN_W         = 6;
  localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd31;
  localparam logic [KLEN_W-1:0] KLEN_MIN   = 6'd4;
  localparam int CMD_DEPTH      = 4;
  localparam int RES_DEPTH      = 4;

  // What the back end has to do with one accepted byte
  typedef enum logic [1:0] {
    K_LOAD     = 2'd0,  // first byte of a super-k-mer
    K_GATHER   = 2'd1,  // whole header byte, k-mer not yet complete
    K_COMPLETE = 2'd2,  // header byte that completes the first k-mer
    K_EXTEND   = 2'd3   // one k-mer per valid base
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  ins;   // bases taken from the top of a completing byte
    logic [7:0]  data;
  } cmd_t;

  // Selects the low cnt bases of a byte
  function automatic logic [7:0] low_sel(input logic [1:0] cnt);
    logic [7:0] m;
    case (cnt)
      2'd0:    m = 8'b0000_0000;
      2'd1:    m = 8'b0000_0011;
      2'd2:    m = 8'b0000_1111;
      default: m = 8'b0011_1111;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/skmx_fifo.sv =====
// Small register queue, used between front and back end and for results.
// No package dependency.
`timescale 1ns / 1ps

module skmx_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [DW-1:0]              data_i,
  input  logic                       pop_i,
  output logic [DW-1:0]              data_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/skmx_front.sv =====
// Front end: accepts bytes, tracks the header phase and classifies each item.
// Depends on skmx_pkg.
`timescale 1ns / 1ps

module skmx_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [7:0]                  data_i,
  input  logic [skmx_pkg::KLEN_W-1:0] k_i,
  input  logic                        cmd_full_i,
  output logic                        cmd_push_o,
  output skmx_pkg::cmd_t              cmd_o
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_GATHER = 2'd1;
  localparam logic [1:0] PH_EXTEND = 2'd2;

  logic [1:0]                  phase_q, phase_d;
  logic [skmx_pkg::KLEN_W-1:0] need_q, need_d;
  logic [1:0]                  cnt;
  logic                        accept;

  assign cnt    = data_i[7:6];
  assign accept = push_i & ~cmd_full_i;

  always_comb begin
    phase_d    = phase_q;
    need_d     = need_q;
    cmd_o.data = data_i;
    cmd_o.ins  = 2'd0;
    cmd_o.kind = skmx_pkg::K_LOAD;
    cmd_push_o = 1'b0;
    if (accept) begin
      cmd_push_o = 1'b1;
      case (phase_q)
        PH_GATHER: begin
          if (need_q > 6'd3) begin
            cmd_o.kind = skmx_pkg::K_GATHER;
            need_d     = need_q - 6'd3;
          end else begin
            cmd_o.kind = skmx_pkg::K_COMPLETE;
            cmd_o.ins  = need_q[1:0];
            need_d     = '0;
            // a header byte that needed all three bases always keeps going
            phase_d    = (need_q == 6'd3 || cnt == 2'd3) ? PH_EXTEND : PH_IDLE;
          end
        end
        PH_EXTEND: begin
          cmd_o.kind = skmx_pkg::K_EXTEND;
          cmd_push_o = (cnt != 2'd0);
          need_d     = '0;
          phase_d    = (cnt == 2'd3) ? PH_EXTEND : PH_IDLE;
        end
        default: begin
          // idle, and the unused code, start a super-k-mer
          cmd_o.kind = skmx_pkg::K_LOAD;
          need_d     = k_i - {4'd0, cnt};
          phase_d    = PH_GATHER;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      need_q  <= '0;
    end else begin
      phase_q <= phase_d;
      need_q  <= need_d;
    end
  end

endmodule

// ===== rtl/core/skmx_back.sv =====
// Back end: holds forward and reverse-complement k-mers, applies one base per
// cycle while results fit, registers k-mers for min compare. Uses skmx_pkg.
`timescale 1ns / 1ps

module skmx_back #(
  parameter int KMER_WORD_BITS = skmx_pkg::KMER_WORD_BITS,
  parameter int RES_DEPTH      = skmx_pkg::RES_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [skmx_pkg::KLEN_W-1:0]          k_i,
  input  logic                                 cmd_valid_i,
  input  skmx_pkg::cmd_t                       cmd_i,
  output logic                                 cmd_pop_o,
  input  logic [$clog2(RES_DEPTH+1)-1:0]       res_cnt_i,
  output logic                                 res_push_o,
  output logic [KMER_WORD_BITS+1:0]            res_data_o
);

  localparam int W   = KMER_WORD_BITS;
  localparam int NB  = W / 2;
  localparam int SHW = $clog2(W+1);
  localparam int CW  = $clog2(RES_DEPTH+1);

  localparam logic [1:0] S_INS = 2'd0;
  localparam logic [1:0] S_RC  = 2'd1;
  localparam logic [1:0] S_EXT = 2'd2;

  logic [W-1:0]   fwd_q, fwd_d, rc_q, rc_d;
  logic [1:0]     step_q, step_d, j_q, j_d;
  logic           pend_q, pend_d, first_q, first_d, last_q, last_d;

  logic [W-1:0]   kmask, fwd_ins, rev, rc_full, fwd_ext, rc_ins, rc_ext, kmin;
  logic [SHW-1:0] rc_sh;
  logic [1:0]     cnt, base;
  logic           room, do_ext, ext_last;

  assign cnt = cmd_i.data[7:6];

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      kmask[2*i +: 2]  = (i < int'(k_i)) ? 2'b11 : 2'b00;
      rc_ins[2*i +: 2] = (i == int'(k_i) - 1) ? ~base : 2'b00;
      rev[2*i +: 2]    = ~fwd_q[W-2-2*i +: 2];
    end
  end

  // Reverse complement over the whole word, then drop the unused bases
  assign rc_sh   = SHW'(W - 2 * int'(k_i));
  assign rc_full = rev >> rc_sh;

  always_comb begin
    case (cmd_i.ins)
      2'd0:    fwd_ins = fwd_q;
      2'd1:    fwd_ins = {fwd_q[W-3:0], cmd_i.data[5:4]};
      2'd2:    fwd_ins = {fwd_q[W-5:0], cmd_i.data[5:2]};
      default: fwd_ins = {fwd_q[W-7:0], cmd_i.data[5:0]};
    endcase
  end

  always_comb begin
    case (j_q)
      2'd0:    base = cmd_i.data[5:4];
      2'd1:    base = cmd_i.data[3:2];
      default: base = cmd_i.data[1:0];
    endcase
  end

  assign fwd_ext  = {fwd_q[W-3:0], base} & kmask;
  assign rc_ext   = ((rc_q >> 2) | rc_ins) & kmask;
  assign ext_last = ({1'b0, j_q} + 3'd1) == {1'b0, cnt};
  assign room     = ({1'b0, res_cnt_i} + (CW+1)'(pend_q)) < (CW+1)'(RES_DEPTH);
  assign do_ext   = (cmd_i.kind == skmx_pkg::K_EXTEND) ||
                    (cmd_i.kind == skmx_pkg::K_COMPLETE && step_q == S_EXT);

  always_comb begin
    fwd_d     = fwd_q;
    rc_d      = rc_q;
    step_d    = step_q;
    j_d       = j_q;
    pend_d    = 1'b0;
    first_d   = first_q;
    last_d    = last_q;
    cmd_pop_o = 1'b0;
    if (cmd_valid_i) begin
      if (do_ext) begin
        if (room) begin
          fwd_d   = fwd_ext;
          rc_d    = rc_ext;
          pend_d  = 1'b1;
          first_d = 1'b0;
          last_d  = ext_last;
          if (ext_last) begin
            cmd_pop_o = 1'b1;
            step_d    = S_INS;
            j_d       = 2'd0;
          end else begin
            j_d = j_q + 2'd1;
          end
        end
      end else begin
        case (cmd_i.kind)
          skmx_pkg::K_LOAD: begin
            fwd_d     = W'(cmd_i.data & skmx_pkg::low_sel(cnt));
            rc_d      = '0;
            cmd_pop_o = 1'b1;
          end
          skmx_pkg::K_GATHER: begin
            fwd_d     = {fwd_q[W-7:0], cmd_i.data[5:0]};
            cmd_pop_o = 1'b1;
          end
          skmx_pkg::K_COMPLETE: begin
            if (step_q == S_RC) begin
              if (room) begin
                rc_d    = rc_full;
                pend_d  = 1'b1;
                first_d = 1'b1;
                if (cnt > cmd_i.ins) begin
                  last_d = 1'b0;
                  step_d = S_EXT;
                  j_d    = cmd_i.ins;
                end else begin
                  last_d    = 1'b1;
                  step_d    = S_INS;
                  j_d       = 2'd0;
                  cmd_pop_o = 1'b1;
                end
              end
            end else begin
              fwd_d  = fwd_ins & kmask;
              step_d = S_RC;
            end
          end
          default: begin
            cmd_pop_o = 1'b1;
          end
        endcase
      end
    end
  end

  assign kmin       = (fwd_q < rc_q) ? fwd_q : rc_q;
  assign res_push_o = pend_q;
  assign res_data_o = {kmin, first_q, last_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q   <= '0;
      rc_q    <= '0;
      step_q  <= S_INS;
      j_q     <= 2'd0;
      pend_q  <= 1'b0;
      first_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      fwd_q   <= fwd_d;
      rc_q    <= rc_d;
      step_q  <= step_d;
      j_q     <= j_d;
      pend_q  <= pend_d;
      first_q <= first_d;
      last_q  <= last_d;
    end
  end

endmodule

// ===== rtl/core/superkmer_canonical_kmer_extract_core.sv =====
// A byte passes the command queue, the back-end k-mer registers and the result
// queue; a completing header byte first adds an insert step. Throughput: one
// k-mer per cycle while results fit, set by the back end applying one base per
// cycle; a completing byte inserts, then emits its first k-mer, then extends.
// Reset: queues empty, k = 31, decoder idle waiting for a super-k-mer start.
`timescale 1ns / 1ps

module superkmer_canonical_kmer_extract_core #(
  parameter int KMER_WORD_BITS = skmx_pkg::KMER_WORD_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  skm_byte_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [KMER_WORD_BITS-1:0]   canonical_kmer_o,
  output logic                        first_of_skm_o,
  output logic                        last_of_byte_o,
  input  logic                        kmer_length_we_i,
  input  logic [skmx_pkg::KLEN_W-1:0] kmer_length_i
);

  localparam int W      = KMER_WORD_BITS;
  localparam int KMAX   = W / 2;
  localparam int CMD_W  = $bits(skmx_pkg::cmd_t);
  localparam int RES_W  = W + 2;
  localparam int RCW    = $clog2(skmx_pkg::RES_DEPTH+1);

  logic [skmx_pkg::KLEN_W-1:0] klen_q, k_eff;
  logic                        cmd_push, cmd_full, cmd_empty, cmd_pop;
  skmx_pkg::cmd_t              cmd_in, cmd_head;
  logic [CMD_W-1:0]            cmd_head_bits;
  logic                        res_push, res_full;
  logic [RES_W-1:0]            res_in, res_head;
  logic [RCW-1:0]              res_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= skmx_pkg::KLEN_RESET;
    end else if (kmer_length_we_i) begin
      klen_q <= kmer_length_i;
    end
  end

  always_comb begin
    if (klen_q < skmx_pkg::KLEN_MIN) begin
      k_eff = skmx_pkg::KLEN_MIN;
    end else if (klen_q > skmx_pkg::KLEN_W'(KMAX)) begin
      k_eff = skmx_pkg::KLEN_W'(KMAX);
    end else begin
      k_eff = klen_q;
    end
  end

  assign full = cmd_full;

  skmx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .data_i     (skm_byte_i),
    .k_i        (k_eff),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  skmx_fifo #(
    .DW    (CMD_W),
    .DEPTH (skmx_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head_bits),
    .empty_o (cmd_empty),
    .full_o  (cmd_full),
    .count_o ()
  );

  assign cmd_head = skmx_pkg::cmd_t'(cmd_head_bits);

  skmx_back #(
    .KMER_WORD_BITS (W),
    .RES_DEPTH      (skmx_pkg::RES_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .k_i         (k_eff),
    .cmd_valid_i (~cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_cnt_i   (res_cnt),
    .res_push_o  (res_push),
    .res_data_o  (res_in)
  );

  skmx_fifo #(
    .DW    (RES_W),
    .DEPTH (skmx_pkg::RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty),
    .full_o  (res_full),
    .count_o (res_cnt)
  );

  assign canonical_kmer_o = res_head[W+1:2];
  assign first_of_skm_o   = res_head[1];
  assign last_of_byte_o   = res_head[0];

  // the back end reserves result space before it emits
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result item pushed into a full result queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> !cmd_empty)
    else $error("back end retired an item from an empty command queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> $past(!cmd_empty))
    else $error("result item produced without a command at the back end");

endmodule
